FILE: src/imsp_pkg.sv
// Shared types, constants and helpers of the IMAP sequence set parser.
package imsp_pkg;

	// Field widths
	localparam int CHAR_W  = 8;
	localparam int MSGNO_W = 11;
	localparam int UID_W   = 32;
	localparam int ACC_W   = 32;

	// Default mailbox capacity
	localparam int MAX_MESSAGES_DEF = 1024;

	// Opcodes of an input transaction
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_CHAR = 1'b1;

	// Characters with a meaning of their own
	localparam logic [CHAR_W-1:0] CHAR_END   = 8'h00;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;

	localparam logic [ACC_W-1:0] ACC_SAT = '1;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADDR,
		ST_CMP,
		ST_VERIFY,
		ST_FINISH
	} state_t;

	// Which end of the element the search unit is resolving
	typedef enum logic {
		PH_START,
		PH_END
	} phase_t;

	// Append one decimal digit, saturating at the all-ones value
	function automatic logic [ACC_W-1:0] acc_digit(input logic [ACC_W-1:0] acc,
			input logic [3:0] d);
		logic [ACC_W+3:0] prod;
		prod = (ACC_W+4)'({acc, 3'b000}) + (ACC_W+4)'({acc, 1'b0}) + (ACC_W+4)'(d);
		return (prod[ACC_W+3:ACC_W] != 4'd0) ? ACC_SAT : prod[ACC_W-1:0];
	endfunction

endpackage

FILE: src/imsp_req_if.sv
// Input channel of the parser: table loads and sequence characters.
interface imsp_req_if;
	logic                             valid;
	logic                             ready;
	logic                             opcode;
	logic [imsp_pkg::CHAR_W-1:0]      char_code;
	logic                             use_uid;
	logic [imsp_pkg::MSGNO_W-1:0]     load_msgno;
	logic [imsp_pkg::UID_W-1:0]       load_uid;

	modport source (output valid, opcode, char_code, use_uid, load_msgno, load_uid,
		input ready);
	modport sink (input valid, opcode, char_code, use_uid, load_msgno, load_uid,
		output ready);
endinterface

FILE: src/imsp_rsp_if.sv
// Result channel of the parser: one message-number range per non-empty element, plus set-end results.
interface imsp_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [imsp_pkg::MSGNO_W-1:0]     first_msgno;
	logic [imsp_pkg::MSGNO_W-1:0]     last_msgno;
	logic                             has_range;
	logic                             set_done;

	modport source (output valid, first_msgno, last_msgno, has_range, set_done,
		input ready);
	modport sink (input valid, first_msgno, last_msgno, has_range, set_done,
		output ready);
endinterface

FILE: src/imsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module imsp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: src/imap_sequence_set_parser.sv
// Top level of the IMAP sequence set parser.
//
// req carries one transaction per cycle at most: opcode OP_LOAD writes one
// UID table entry (load_msgno, load_uid), opcode OP_CHAR feeds one byte of
// the sequence set. rsp carries one first/last message-number pair per
// non-empty element, and one result with set_done when byte 0 ends the set.
// The user must write message_count through cfg_wr_en/cfg_wr_data only
// while the block is idle; the block itself does not enforce this. Loads,
// digits and ':' are taken in the idle state. A separator leads, after any
// search, to the finish state, which clamps and emits. In UID mode each
// binary search probe over the UID RAM passes through ST_ADDR (address) and
// ST_CMP (registered read data), up to clog2(count+1) probes; a range runs
// two searches plus at most one check read, all on the single RAM read port.
// req.ready is low while an element is resolved. rsp is held in an output
// register: the next element is parsed while a result waits, and a second
// result waits in the finish state until the receiver takes the first.
// Reset clears the parse state, the output register and message_count; the
// UID table holds no reset value and must be loaded before it is searched.
module imap_sequence_set_parser #(
	parameter int MAX_MESSAGES = imsp_pkg::MAX_MESSAGES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [imsp_pkg::MSGNO_W-1:0]   cfg_wr_data,
	imsp_req_if.sink                       req,
	imsp_rsp_if.source                     rsp
);

	localparam int AW = (MAX_MESSAGES > 1) ? $clog2(MAX_MESSAGES) : 1;
	localparam int CW = $clog2(MAX_MESSAGES + 2);
	localparam int ACC_W = imsp_pkg::ACC_W;
	localparam int MSGNO_W = imsp_pkg::MSGNO_W;

	imsp_pkg::state_t state_q, state_d;
	imsp_pkg::phase_t phase_q, phase_d;

	logic [MSGNO_W-1:0] message_count_q;
	logic [ACC_W-1:0]   start_accum_q, end_accum_q;
	logic               in_range_q;

	logic [ACC_W-1:0]   s_q, s_d, e_q, e_d, key_q, key_d;
	logic [CW-1:0]      low_q, low_d, high_q, high_d, mid_q, mid_d;
	logic               is_range_q, done_q;

	logic               rsp_valid_q;
	logic [MSGNO_W-1:0] first_q, last_q;
	logic               has_range_q, set_done_q;

	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic [imsp_pkg::UID_W-1:0] rd_data;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;

	logic [CW-1:0]      count_c, mid_c;
	logic [ACC_W-1:0]   count32;
	logic               req_acc, is_digit, is_colon, is_sep, need_search;
	logic [3:0]         digit;
	logic [ACC_W-1:0]   lo_c, hi_c;
	logic [ACC_W-1:0]   s_clamp, e_clamp, first_c, last_c;
	logic               nonempty, emit, out_free, out_load;
	logic               srch_end;
	logic [CW-1:0]      srch_res;
	logic               srch_found;

	// Effective message count
	always_comb begin
		if (32'(message_count_q) > 32'(MAX_MESSAGES)) begin
			count_c = CW'(MAX_MESSAGES);
		end else begin
			count_c = CW'(message_count_q);
		end
		count32 = ACC_W'(count_c);
	end

	// Decode the incoming transaction
	assign req.ready   = (state_q == imsp_pkg::ST_IDLE);
	assign req_acc     = req.valid && req.ready;
	assign is_digit    = (req.char_code >= imsp_pkg::CHAR_ZERO) &&
		(req.char_code <= imsp_pkg::CHAR_NINE);
	assign digit       = 4'(req.char_code - imsp_pkg::CHAR_ZERO);
	assign is_colon    = !in_range_q && (req.char_code == imsp_pkg::CHAR_COLON);
	assign is_sep      = req_acc && (req.opcode == imsp_pkg::OP_CHAR) && !is_digit &&
		!is_colon;
	assign need_search = req.use_uid && (in_range_q || (start_accum_q != '0));
	assign lo_c        = (start_accum_q > end_accum_q) ? end_accum_q : start_accum_q;
	assign hi_c        = (start_accum_q > end_accum_q) ? start_accum_q : end_accum_q;

	// Load UID table entries
	assign wr_en   = req_acc && (req.opcode == imsp_pkg::OP_LOAD) &&
		(req.load_msgno != '0) && (32'(req.load_msgno) <= 32'(MAX_MESSAGES));
	assign wr_addr = AW'(32'(req.load_msgno) - 32'd1);

	imsp_ram #(
		.WIDTH (imsp_pkg::UID_W),
		.DEPTH (MAX_MESSAGES)
	) u_uid_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (req.load_uid),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Clamp and decide whether the element emits
	always_comb begin
		s_clamp = (s_q == '0) ? ACC_W'(1) : s_q;
		e_clamp = (e_q > count32) ? count32 : e_q;
		if (is_range_q) begin
			nonempty = (s_clamp <= e_clamp);
			first_c  = s_clamp;
			last_c   = e_clamp;
		end else begin
			nonempty = (s_q != '0) && (s_q <= count32);
			first_c  = s_q;
			last_c   = s_q;
		end
		emit     = nonempty || done_q;
		out_free = !rsp_valid_q || rsp.ready;
	end

	// Sequencer: next state, search registers and RAM read port
	always_comb begin
		state_d    = state_q;
		phase_d    = phase_q;
		s_d        = s_q;
		e_d        = e_q;
		key_d      = key_q;
		low_d      = low_q;
		high_d     = high_q;
		mid_d      = mid_q;
		rd_en      = 1'b0;
		rd_addr    = AW'(mid_q - CW'(1));
		out_load   = 1'b0;
		srch_end   = 1'b0;
		srch_res   = high_q;
		srch_found = 1'b0;
		mid_c      = low_q + ((high_q - low_q) >> 1);

		unique case (state_q)
			imsp_pkg::ST_IDLE: begin
				if (is_sep) begin
					s_d     = in_range_q ? lo_c : start_accum_q;
					e_d     = hi_c;
					key_d   = in_range_q ? lo_c : start_accum_q;
					low_d   = CW'(1);
					high_d  = count_c;
					phase_d = imsp_pkg::PH_START;
					state_d = need_search ? imsp_pkg::ST_ADDR : imsp_pkg::ST_FINISH;
				end
			end
			imsp_pkg::ST_ADDR: begin
				if (low_q > high_q) begin
					srch_end = 1'b1;
					srch_res = high_q;
				end else begin
					mid_d   = mid_c;
					rd_en   = 1'b1;
					rd_addr = AW'(mid_c - CW'(1));
					state_d = imsp_pkg::ST_CMP;
				end
			end
			imsp_pkg::ST_CMP: begin
				if (rd_data == key_q) begin
					srch_end   = 1'b1;
					srch_res   = mid_q;
					srch_found = 1'b1;
				end else begin
					if (rd_data > key_q) begin
						high_d = mid_q - CW'(1);
					end else begin
						low_d = mid_q + CW'(1);
					end
					state_d = imsp_pkg::ST_ADDR;
				end
			end
			imsp_pkg::ST_VERIFY: begin
				if (rd_data == key_q) begin
					s_d = ACC_W'(mid_q);
				end else begin
					s_d = is_range_q ? (ACC_W'(mid_q) + ACC_W'(1)) : '0;
				end
				state_d = is_range_q ? imsp_pkg::ST_ADDR : imsp_pkg::ST_FINISH;
			end
			imsp_pkg::ST_FINISH: begin
				if (!emit) begin
					state_d = imsp_pkg::ST_IDLE;
				end else if (out_free) begin
					out_load = 1'b1;
					state_d  = imsp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = imsp_pkg::ST_IDLE;
			end
		endcase

		// Resolve the end of a search
		if (srch_end) begin
			if (phase_q == imsp_pkg::PH_END) begin
				e_d     = ACC_W'(srch_res);
				state_d = imsp_pkg::ST_FINISH;
			end else if (!srch_found && (srch_res != '0)) begin
				// Near miss: check the entry the search settled on
				mid_d   = srch_res;
				rd_en   = 1'b1;
				rd_addr = AW'(srch_res - CW'(1));
				state_d = imsp_pkg::ST_VERIFY;
			end else begin
				if (srch_found) begin
					s_d = ACC_W'(srch_res);
				end else begin
					s_d = is_range_q ? ACC_W'(1) : '0;
				end
				state_d = is_range_q ? imsp_pkg::ST_ADDR : imsp_pkg::ST_FINISH;
			end
		end

		// Set up the search for the range end
		if (is_range_q && (phase_q == imsp_pkg::PH_START) &&
				(state_d == imsp_pkg::ST_ADDR) &&
				(state_q == imsp_pkg::ST_VERIFY || srch_end)) begin
			phase_d = imsp_pkg::PH_END;
			key_d   = e_q;
			low_d   = CW'(1);
			high_d  = count_c;
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= imsp_pkg::ST_IDLE;
			phase_q <= imsp_pkg::PH_START;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	// Search datapath
	always_ff @(posedge clk) begin
		s_q    <= s_d;
		e_q    <= e_d;
		key_q  <= key_d;
		low_q  <= low_d;
		high_q <= high_d;
		mid_q  <= mid_d;
		if (is_sep) begin
			is_range_q <= in_range_q;
			done_q     <= (req.char_code == imsp_pkg::CHAR_END);
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			message_count_q <= '0;
		end else if (cfg_wr_en) begin
			message_count_q <= cfg_wr_data;
		end
	end

	// Accumulate digits, open ranges, drop the element at a separator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_accum_q <= '0;
			end_accum_q   <= '0;
			in_range_q    <= 1'b0;
		end else if (req_acc && (req.opcode == imsp_pkg::OP_CHAR)) begin
			if (is_digit) begin
				if (in_range_q) begin
					end_accum_q <= imsp_pkg::acc_digit(end_accum_q, digit);
				end else begin
					start_accum_q <= imsp_pkg::acc_digit(start_accum_q, digit);
				end
			end else if (is_colon) begin
				in_range_q  <= 1'b1;
				end_accum_q <= '0;
			end else begin
				start_accum_q <= '0;
				if (in_range_q) begin
					in_range_q  <= 1'b0;
					end_accum_q <= '0;
				end
			end
		end
	end

	// Output register: hold a result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			first_q     <= nonempty ? first_c[MSGNO_W-1:0] : '0;
			last_q      <= nonempty ? last_c[MSGNO_W-1:0] : '0;
			has_range_q <= nonempty;
			set_done_q  <= done_q;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.first_msgno = first_q;
	assign rsp.last_msgno  = last_q;
	assign rsp.has_range   = has_range_q;
	assign rsp.set_done    = set_done_q;

endmodule

FILE: src/imsp_checker.sv
// Port-level checks of the IMAP sequence set parser, bound to the top level.
module imsp_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [imsp_pkg::MSGNO_W-1:0] first_msgno,
	input logic [imsp_pkg::MSGNO_W-1:0] last_msgno,
	input logic                         has_range,
	input logic                         set_done
);

	// Hold a stalled result transaction
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(first_msgno) &&
		$stable(last_msgno) && $stable(has_range) && $stable(set_done))
		else $error("rsp changed while stalled");

	// A range starts at message 1 or later and does not run backward
	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && has_range |-> (first_msgno != '0) && (first_msgno <= last_msgno))
		else $error("rsp range out of order");

	// A result without a range only marks the end of the set
	a_empty_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !has_range |-> set_done)
		else $error("empty result without set end");

	// An empty result carries zero message numbers
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !has_range |-> (first_msgno == '0) && (last_msgno == '0))
		else $error("empty result with message numbers");

endmodule

bind imap_sequence_set_parser imsp_checker u_imsp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.first_msgno (rsp.first_msgno),
	.last_msgno  (rsp.last_msgno),
	.has_range   (rsp.has_range),
	.set_done    (rsp.set_done)
);

FILE: test/imsp_range_checker.sv
// Checker of the sequence set parser: predicts each range from req and compares it on rsp.
module imsp_range_checker #(
	parameter int MAX_MESSAGES = imsp_pkg::MAX_MESSAGES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [imsp_pkg::MSGNO_W-1:0] cfg_wr_data,
	imsp_req_if                          req,
	imsp_rsp_if                          rsp,
	output int                           mismatches,
	output int                           waiting
);
	timeunit 1ns;
	timeprecision 1ps;
	import imsp_pkg::*;

	typedef struct packed {
		logic [MSGNO_W-1:0] first_msgno;
		logic [MSGNO_W-1:0] last_msgno;
		logic               has_range;
		logic               set_done;
	} range_t;

	range_t             expected_ranges [$];
	logic [MSGNO_W-1:0] mbox_count;
	logic [ACC_W-1:0]   start_num;
	logic [ACC_W-1:0]   end_num;
	logic               reading_end;
	logic [UID_W-1:0]   uid_of_msg [1:MAX_MESSAGES];

	task automatic report_mismatch(input string msg);
		$display("%0t imsp_range_checker: %s", $time, msg);
		mismatches++;
	endtask

	// Shift in one decimal digit, stick at all ones on overflow
	function automatic logic [ACC_W-1:0] append_digit(input logic [ACC_W-1:0] acc,
			input logic [3:0] d);
		logic [ACC_W+3:0] wide;
		wide = (ACC_W+4)'(acc) * 10 + (ACC_W+4)'(d);
		return (wide[ACC_W+3:ACC_W] != 0) ? '1 : wide[ACC_W-1:0];
	endfunction

	// Message number holding key, else the highest one below it (0 if none)
	function automatic int locate_uid(input logic [UID_W-1:0] key, input int unsigned cnt);
		int lo;
		int hi;
		int mid;
		lo = 1;
		hi = int'(cnt);
		while (lo <= hi) begin
			mid = (hi - lo) / 2 + lo;
			if (uid_of_msg[mid] == key)
				return mid;
			if (uid_of_msg[mid] > key)
				hi = mid - 1;
			else
				lo = mid + 1;
		end
		return hi;
	endfunction

	// Advance the parser by one accepted transaction and queue its range, if any
	task automatic step_parser(input logic op, input logic [CHAR_W-1:0] ch,
			input logic uid_mode, input logic [MSGNO_W-1:0] msgno,
			input logic [UID_W-1:0] uid);
		logic [ACC_W-1:0] lo_end;
		logic [ACC_W-1:0] hi_end;
		logic [ACC_W-1:0] tmp;
		int unsigned      cnt;
		int               idx;
		logic             done;
		logic             hit;
		range_t           r;
		cnt = (mbox_count > MAX_MESSAGES) ? MAX_MESSAGES : mbox_count;
		if (op == OP_LOAD) begin
			if (msgno >= 1 && msgno <= MAX_MESSAGES)
				uid_of_msg[msgno] = uid;
			return;
		end
		if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
			if (reading_end)
				end_num = append_digit(end_num, 4'(ch - CHAR_ZERO));
			else
				start_num = append_digit(start_num, 4'(ch - CHAR_ZERO));
			return;
		end
		if (!reading_end && ch == CHAR_COLON) begin
			reading_end = 1'b1;
			end_num = '0;
			return;
		end
		done = (ch == CHAR_END);
		if (reading_end) begin
			// Range: order the ends, map UIDs, clamp to the mailbox
			lo_end = start_num;
			hi_end = end_num;
			if (lo_end > hi_end) begin
				tmp = lo_end;
				lo_end = hi_end;
				hi_end = tmp;
			end
			if (uid_mode) begin
				idx = locate_uid(lo_end, cnt);
				if (idx == 0 || lo_end != uid_of_msg[idx])
					idx++;
				lo_end = idx;
				hi_end = locate_uid(hi_end, cnt);
			end
			if (lo_end < 1)
				lo_end = 1;
			if (hi_end > cnt)
				hi_end = cnt;
			hit = (lo_end <= hi_end);
			reading_end = 1'b0;
			end_num = '0;
		end else begin
			// Single number: a UID must match exactly
			lo_end = start_num;
			if (lo_end != 0 && uid_mode) begin
				idx = locate_uid(lo_end, cnt);
				if (idx == 0 || lo_end != uid_of_msg[idx])
					idx = 0;
				lo_end = idx;
			end
			hi_end = lo_end;
			hit = (lo_end > 0 && lo_end <= cnt);
		end
		start_num = '0;
		if (hit || done) begin
			r.first_msgno = hit ? lo_end[MSGNO_W-1:0] : '0;
			r.last_msgno  = hit ? hi_end[MSGNO_W-1:0] : '0;
			r.has_range   = hit;
			r.set_done    = done;
			expected_ranges.push_back(r);
		end
	endtask

	// Compare one result transaction with the oldest expected range
	task automatic check_range(input range_t got);
		range_t want;
		if (expected_ranges.size() == 0) begin
			report_mismatch($sformatf("unexpected result first=%0d last=%0d has_range=%0b done=%0b",
				got.first_msgno, got.last_msgno, got.has_range, got.set_done));
			return;
		end
		want = expected_ranges.pop_front();
		if (got.first_msgno != want.first_msgno)
			report_mismatch($sformatf("first_msgno %0d, expected %0d",
				got.first_msgno, want.first_msgno));
		if (got.last_msgno != want.last_msgno)
			report_mismatch($sformatf("last_msgno %0d, expected %0d",
				got.last_msgno, want.last_msgno));
		if (got.has_range != want.has_range)
			report_mismatch($sformatf("has_range %0b, expected %0b",
				got.has_range, want.has_range));
		if (got.set_done != want.set_done)
			report_mismatch($sformatf("set_done %0b, expected %0b",
				got.set_done, want.set_done));
	endtask

	// Watch config writes and both channels at each rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbox_count  = '0;
			start_num   = '0;
			end_num     = '0;
			reading_end = 1'b0;
			mismatches  = 0;
			waiting     = 0;
			expected_ranges.delete();
		end else begin
			if (cfg_wr_en)
				mbox_count = cfg_wr_data;
			if (req.valid && req.ready)
				step_parser(req.opcode, req.char_code, req.use_uid, req.load_msgno, req.load_uid);
			if (rsp.valid && rsp.ready)
				check_range({rsp.first_msgno, rsp.last_msgno, rsp.has_range, rsp.set_done});
			waiting = expected_ranges.size();
		end
	end

endmodule

FILE: test/imap_sequence_set_parser_test.sv
// Top of the sequence set parser testbench: clock, reset, stimulus and verdict.
module imap_sequence_set_parser_test;
	timeunit 1ns;
	timeprecision 1ps;
	import imsp_pkg::*;

	localparam int     MAX_MSG       = MAX_MESSAGES_DEF;
	localparam int     RANDOM_ITEMS  = 1100;
	localparam int     PHASE_ITEMS   = 90;
	localparam int     CALM_ITEMS    = 150;
	localparam int     SETTLE_CYCLES = 64;
	localparam longint CYCLE_LIMIT   = 1000000;
	localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
	localparam int unsigned COUNT_PLAN [12] = '{0, 1, 2, 3, 1024, 2047, 7, 100, 513, 1023,
		1025, 64};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [MSGNO_W-1:0]  cfg_wr_data;
	int                  mismatches;
	int                  waiting;
	logic [UID_W-1:0]    uid_shadow [1:MAX_MSG];
	int unsigned         live_count;
	int                  sent_items;
	int                  gap_pct;
	int                  stall_pct;
	logic                mix_loads;
	longint              cycle_count = 0;

	imsp_req_if req ();
	imsp_rsp_if rsp ();

	imap_sequence_set_parser #(
		.MAX_MESSAGES(MAX_MSG)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req        (req),
		.rsp        (rsp)
	);

	imsp_range_checker #(
		.MAX_MESSAGES(MAX_MSG)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req        (req),
		.rsp        (rsp),
		.mismatches (mismatches),
		.waiting    (waiting)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("imap_sequence_set_parser_test: FAIL");
			$finish;
		end
	end

	// Stall the result channel in random bursts
	initial begin
		int stall_left;
		rsp.ready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left == 0 && $urandom_range(0, 99) < stall_pct)
				stall_left = $urandom_range(1, 18);
			if (stall_left > 0) begin
				rsp.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// Present one transaction after an optional gap and hold it until accepted
	task automatic send_req(input logic op, input logic [CHAR_W-1:0] ch, input logic uid_mode,
			input logic [MSGNO_W-1:0] msgno, input logic [UID_W-1:0] uid);
		int gap;
		gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 18) : 0;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid      <= 1'b1;
		req.opcode     <= op;
		req.char_code  <= ch;
		req.use_uid    <= uid_mode;
		req.load_msgno <= msgno;
		req.load_uid   <= uid;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		@(negedge clk);
		sent_items++;
	endtask

	// Rewrite one table entry in order, or load to a bad index
	task automatic touch_table();
		int unsigned      k;
		logic [UID_W-1:0] lo;
		logic [UID_W-1:0] hi;
		if ($urandom_range(0, 1) == 0) begin
			k = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(MAX_MSG + 1, 2047);
			send_req(OP_LOAD, CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				MSGNO_W'(k), $urandom);
			return;
		end
		k = $urandom_range(1, MAX_MSG);
		lo = (k > 1) ? uid_shadow[k-1] + 1 : '0;
		hi = (k < MAX_MSG) ? uid_shadow[k+1] - 1 : '1;
		uid_shadow[k] = $urandom_range(hi, lo);
		send_req(OP_LOAD, CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			MSGNO_W'(k), uid_shadow[k]);
	endtask

	task automatic send_char(input logic [CHAR_W-1:0] ch, input logic uid_mode);
		if (mix_loads && $urandom_range(0, 99) < 2)
			touch_table();
		send_req(OP_CHAR, ch, uid_mode, MSGNO_W'($urandom_range(0, 2047)), $urandom);
	endtask

	task automatic send_text(input string s, input logic uid_mode);
		foreach (s[i])
			send_char(s[i], uid_mode);
	endtask

	// Write message_count once the block has drained
	task automatic write_count(input logic [MSGNO_W-1:0] v);
		req.valid <= 1'b0;
		while (waiting != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		live_count = (v > MAX_MSG) ? MAX_MSG : v;
	endtask

	// Load an ascending UID table into every message slot
	task automatic fill_table();
		uid_shadow[1] = $urandom_range(1, 4);
		for (int k = 2; k <= MAX_MSG; k++) begin
			if (k <= 8 || $urandom_range(0, 3) == 0)
				uid_shadow[k] = uid_shadow[k-1] + $urandom_range(1, 3);
			else
				uid_shadow[k] = uid_shadow[k-1] + $urandom_range(1, 4000000);
		end
		for (int k = 1; k <= MAX_MSG; k++)
			send_req(OP_LOAD, CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				MSGNO_W'(k), uid_shadow[k]);
	endtask

	// Draw a decimal number that lands near the mailbox or table edges
	function automatic string pick_number(input logic uid_mode);
		int unsigned      r;
		int unsigned      k;
		int unsigned      top_k;
		logic [UID_W-1:0] v;
		r = $urandom_range(0, 99);
		top_k = (live_count == 0) ? 1 : live_count;
		k = $urandom_range(1, top_k);
		if (r >= 94)
			return r[0] ? "4294967295" : "000000099999999999";
		if (r >= 88)
			return $sformatf("%0d", $urandom);
		if (r >= 82)
			return "0";
		if (!uid_mode) begin
			if (r >= 72)
				return $sformatf("00%0d", $urandom_range(0, top_k + 2));
			return $sformatf("%0d", $urandom_range(0, top_k + 2));
		end
		if (r < 45)
			v = uid_shadow[k];
		else if (r < 58)
			v = uid_shadow[k] + 1;
		else if (r < 70)
			v = uid_shadow[k] - 1;
		else if (r < 76)
			v = $urandom_range(0, uid_shadow[1]);
		else
			v = uid_shadow[top_k] + $urandom_range(0, 50);
		return $sformatf("%0d", v);
	endfunction

	function automatic logic [CHAR_W-1:0] pick_separator();
		logic [CHAR_W-1:0] c;
		if ($urandom_range(0, 3) != 0)
			return CHAR_COMMA;
		c = CHAR_W'($urandom_range(1, 255));
		while ((c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_COLON)
			c = CHAR_W'($urandom_range(1, 255));
		return c;
	endfunction

	// Mostly keep the set's mode on a separator, now and then flip it
	function automatic logic sep_mode(input logic uid_mode);
		return ($urandom_range(0, 19) == 0) ? ~uid_mode : uid_mode;
	endfunction

	// Send one well-formed set with random content, some elements broken
	task automatic send_set(input logic uid_mode);
		int n;
		int kind;
		n = $urandom_range(0, 4);
		for (int i = 0; i < n; i++) begin
			if (i > 0)
				send_char(pick_separator(), sep_mode(uid_mode));
			kind = $urandom_range(0, 99);
			if (kind >= 40 && kind < 95 && kind != 85 && kind != 90) begin
				if (kind < 80)
					send_text(pick_number(uid_mode), uid_mode);
				send_char(CHAR_COLON, uid_mode);
				if (kind < 90)
					send_text(pick_number(uid_mode), uid_mode);
			end else begin
				send_text(pick_number(uid_mode), uid_mode);
			end
			// Chain a second colon: it ends the range instead of opening one
			if (kind >= 95) begin
				send_char(CHAR_COLON, uid_mode);
				send_text(pick_number(uid_mode), uid_mode);
				send_char(CHAR_COLON, uid_mode);
				send_text(pick_number(uid_mode), uid_mode);
			end
		end
		send_char(CHAR_END, sep_mode(uid_mode));
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 8)) begin
			if ($urandom_range(0, 3) == 0)
				send_char(CHAR_COLON, 1'($urandom_range(0, 1)));
			else
				send_char(CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		end
	endtask

	// Corner cases of the parser with a five-message mailbox
	task automatic run_directed();
		write_count(MSGNO_W'(5));
		send_text("9:2:0,", 1'b0);
		send_char(8'hFF, 1'b0);
		send_text(":4,", 1'b0);
		send_req(OP_LOAD, CHAR_END, 1'b0, '0, '1);
		send_text("4294967296", 1'b0);
		send_char(CHAR_END, 1'b0);
		send_char(CHAR_END, 1'b0);
		send_text($sformatf("%0d:%0d,%0d,", uid_shadow[4], uid_shadow[2] + 1, uid_shadow[3]),
			1'b1);
		send_req(OP_LOAD, CHAR_COLON, 1'b1, 11'd2047, $urandom);
		send_text($sformatf("%0d", uid_shadow[5] + 1), 1'b1);
		send_char(CHAR_END, 1'b1);
	endtask

	task automatic run_phase(input int unsigned new_count, input logic calm);
		int stop_at;
		int r;
		write_count(MSGNO_W'(new_count));
		gap_pct   = calm ? 0 : 10 * $urandom_range(0, 3);
		stall_pct = calm ? 0 : 5 * $urandom_range(0, 3);
		mix_loads = 1'b1;
		stop_at = sent_items + PHASE_ITEMS;
		while (sent_items < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 85)
				send_set(1'($urandom_range(0, 1)));
			else if (r < 95)
				send_noise();
			else
				touch_table();
		end
		send_char(CHAR_END, 1'b0);
	endtask

	initial begin
		int          phase;
		int          base;
		int unsigned next_count;
		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_wr_data    = '0;
		req.valid      = 1'b0;
		req.opcode     = OP_CHAR;
		req.char_code  = CHAR_END;
		req.use_uid    = 1'b0;
		req.load_msgno = '0;
		req.load_uid   = '0;
		gap_pct        = 0;
		stall_pct      = 0;
		mix_loads      = 1'b0;
		sent_items     = 0;
		live_count     = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		fill_table();
		run_directed();

		// Random phases over a sweep of mailbox sizes, quiet at the tail
		base = sent_items;
		phase = 0;
		while (sent_items - base < RANDOM_ITEMS) begin
			if (phase < 12)
				next_count = COUNT_PLAN[phase];
			else if ($urandom_range(0, 3) == 0)
				next_count = $urandom_range(0, 2047);
			else
				next_count = $urandom_range(1, 40);
			run_phase(next_count, (sent_items - base) >= RANDOM_ITEMS - CALM_ITEMS);
			phase++;
		end

		// Drain the last results
		stall_pct = 0;
		req.valid <= 1'b0;
		while (waiting != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("imap_sequence_set_parser_test: PASS");
		else
			$display("imap_sequence_set_parser_test: FAIL");
		$finish;
	end

endmodule

FILE: files.f
src/imsp_pkg.sv
src/imsp_req_if.sv
src/imsp_rsp_if.sv
src/imsp_ram.sv
src/imap_sequence_set_parser.sv
src/imsp_checker.sv
test/imsp_range_checker.sv
test/imap_sequence_set_parser_test.sv
